// ===== sv/owbm_pkg.sv =====
// Package for the 1-Wire bus master: codes, timing constants and queue word type.
`timescale 1ns / 1ps

package owbm_pkg;

   // Bus timing in microseconds
   localparam logic [9:0] RST_LOW_US    = 10'd480;
   localparam logic [9:0] RST_SAMPLE_US = 10'd550;   // 480 + 70
   localparam logic [9:0] RST_END_US    = 10'd960;   // 480 + 70 + 410
   localparam logic [9:0] SLOT_US       = 10'd70;
   localparam logic [9:0] W1_LOW_US     = 10'd6;
   localparam logic [9:0] W0_LOW_US     = 10'd60;
   localparam logic [9:0] RD_LOW_US     = 10'd6;
   localparam logic [9:0] RD_SAMPLE_US  = 10'd15;    // 6 + 9
   localparam logic [2:0] LAST_BIT      = 3'd7;

   localparam int unsigned QUEUE_DEPTH = 2;

   // Input action codes
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_RESET = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // Sequence modes
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_RESET = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_NONE       = 3'd0,
      ST_PRESENCE   = 3'd1,
      ST_NO_DEVICE  = 3'd2,
      ST_WRITE_DONE = 3'd3,
      ST_READ_DONE  = 3'd4,
      ST_REFUSED    = 3'd5
   } status_type;

   // Classified word passed from front to back
   typedef struct packed {
      logic       is_tick;
      kind_type   kind;
      logic [7:0] data_byte;
      logic       line_level;
   } entry_type;

endpackage

// ===== sv/one_wire_bus_master_top.sv =====
// Top level of the 1-Wire bus master: front stage, queue and bus engine.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_*): one word per command or tick. req_action selects
//   tick, start reset, start byte write or start byte read; req_data_byte is
//   the byte to send and req_line_level the sampled bus level for a tick.
//   Response channel (rsp_*): exactly one word per request word, in order,
//   with the pin drive, busy flag, status and the read byte.
//   csr_we/csr_wdata set ticks_per_us; write it only while the block is idle.
//   Path from request acceptance to response valid: front register, queue,
//   response register. Throughput: one word per cycle while rsp_ready is
//   high, with the bus engine updated once per popped word.
//   Reset: the bus engine goes idle, ticks_per_us returns to 1 and all queued
//   words are dropped.
//   Stalls: when rsp_ready is low the response register holds its word, the
//   two-entry queue and the front register fill, and then req_ready drops.
module one_wire_bus_master_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_line_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_drive_low,
   output logic       rsp_busy_res,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_read_value,
   input  logic       csr_we,
   input  logic [9:0] csr_wdata
);
   import owbm_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   owbm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_line_level (req_line_level),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   owbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   owbm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_entry          (pop_entry),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_line_drive_low (rsp_line_drive_low),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value)
   );

endmodule

// ===== sv/owbm_front.sv =====
// Front stage: accepts request words, classifies the action and registers them.
`timescale 1ns / 1ps

module owbm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [7:0]          req_data_byte,
   input  logic                req_line_level,
   output logic                push_valid,
   input  logic                push_ready,
   output owbm_pkg::entry_type push_entry
);
   import owbm_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      load;

   // Take a new word whenever the holding register is empty or drains
   assign req_ready  = !valid_ff || push_ready;
   assign load       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   // Classify
   always_comb begin
      entry_in.kind       = kind_type'(req_action);
      entry_in.is_tick    = (kind_type'(req_action) == KIND_TICK);
      entry_in.data_byte  = req_data_byte;
      entry_in.line_level = req_line_level;
      valid_in = load || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== sv/owbm_queue.sv =====
// Two-entry queue between the front stage and the bus engine.
`timescale 1ns / 1ps

module owbm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  owbm_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output owbm_pkg::entry_type pop_entry
);
   import owbm_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/owbm_back.sv =====
// Bus engine: runs reset, write and read sequences and registers the response word.
`timescale 1ns / 1ps

module owbm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [9:0]          csr_wdata,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  owbm_pkg::entry_type pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_line_drive_low,
   output logic                rsp_busy_res,
   output logic [2:0]          rsp_status,
   output logic [7:0]          rsp_read_value
);
   import owbm_pkg::*;

   // Sequence state
   mode_type   mode_ff, mode_in;
   logic [9:0] slot_us_ff, slot_us_in;
   logic [9:0] prescale_ff, prescale_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       presence_ff, presence_in;
   logic [9:0] tpu_ff;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       drive_ff, drive_in;
   logic       busy_ff, busy_in;
   status_type status_ff, status_in;
   logic [7:0] rval_ff, rval_in;

   logic       pop;
   logic       drive_now;
   logic [9:0] tpu_eff;
   logic [9:0] pc_next;
   logic [9:0] t;

   assign pop       = pop_valid && pop_ready;
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign tpu_eff   = (tpu_ff == '0) ? 10'd1 : tpu_ff;

   // Line drive from the current slot time
   always_comb begin
      case (mode_ff)
         MODE_RESET: drive_now = (slot_us_ff < RST_LOW_US);
         MODE_WRITE: drive_now = (slot_us_ff < (shift_ff[0] ? W1_LOW_US : W0_LOW_US));
         MODE_READ:  drive_now = (slot_us_ff < RD_LOW_US);
         default:    drive_now = 1'b0;
      endcase
   end

   // Sequence next state and response payload
   always_comb begin
      mode_in     = mode_ff;
      slot_us_in  = slot_us_ff;
      prescale_in = prescale_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      presence_in = presence_ff;
      drive_in    = 1'b0;
      status_in   = ST_NONE;
      rval_in     = '0;
      pc_next     = prescale_ff + 10'd1;
      t           = slot_us_ff;

      if (!pop_entry.is_tick) begin
         if (mode_ff != MODE_IDLE) begin
            drive_in  = drive_now;
            status_in = ST_REFUSED;
         end else begin
            mode_in     = mode_type'(pop_entry.kind);
            slot_us_in  = '0;
            prescale_in = '0;
            bit_in      = '0;
            presence_in = 1'b0;
            shift_in    = (pop_entry.kind == KIND_WRITE) ? pop_entry.data_byte : 8'd0;
            drive_in    = 1'b1;
         end
      end else if (mode_ff != MODE_IDLE) begin
         drive_in = drive_now;

         // Sample on the first tick of the sample microsecond
         if (prescale_ff == '0) begin
            if (mode_ff == MODE_RESET && slot_us_ff == RST_SAMPLE_US) begin
               presence_in = !pop_entry.line_level;
            end
            if (mode_ff == MODE_READ && slot_us_ff == RD_SAMPLE_US) begin
               shift_in = {pop_entry.line_level, shift_ff[7:1]};
            end
         end

         // Microsecond prescaler
         if (pc_next >= tpu_eff) begin
            prescale_in = '0;
            t = slot_us_ff + 10'd1;
         end else begin
            prescale_in = pc_next;
         end
         slot_us_in = t;

         // End of sequence or slot
         if (mode_ff == MODE_RESET) begin
            if (t == RST_END_US) begin
               status_in  = presence_in ? ST_PRESENCE : ST_NO_DEVICE;
               mode_in    = MODE_IDLE;
               slot_us_in = '0;
            end
         end else if (t == SLOT_US) begin
            slot_us_in = '0;
            if (mode_ff == MODE_WRITE) begin
               shift_in = {1'b0, shift_ff[7:1]};
            end
            if (bit_ff == LAST_BIT) begin
               if (mode_ff == MODE_WRITE) begin
                  status_in = ST_WRITE_DONE;
               end else begin
                  status_in = ST_READ_DONE;
                  rval_in   = shift_in;
               end
               mode_in = MODE_IDLE;
               bit_in  = '0;
            end else begin
               bit_in = bit_ff + 3'd1;
            end
         end
      end

      busy_in      = (mode_in != MODE_IDLE);
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         slot_us_ff   <= '0;
         prescale_ff  <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         presence_ff  <= 1'b0;
         tpu_ff       <= 10'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            mode_ff     <= mode_in;
            slot_us_ff  <= slot_us_in;
            prescale_ff <= prescale_in;
            bit_ff      <= bit_in;
            shift_ff    <= shift_in;
            presence_ff <= presence_in;
         end
         if (csr_we) begin
            tpu_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         drive_ff  <= drive_in;
         busy_ff   <= busy_in;
         status_ff <= status_in;
         rval_ff   <= rval_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_drive_low = drive_ff;
   assign rsp_busy_res       = busy_ff;
   assign rsp_status         = status_ff;
   assign rsp_read_value     = rval_ff;

endmodule

// ===== dv/tb.sv =====
// Testbench for the 1-Wire bus master: directed plan, random bus sequences, word-by-word check.
`timescale 1ns / 1ps

module tb;
   import owbm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_PHASES  = 4;
   localparam int PHASE_WORDS = 25;

   // Expected response word, laid out like the response ports
   typedef struct packed {
      logic       drive;
      logic       busy;
      status_type status;
      logic [7:0] value;
   } rsp_word_type;

   // One line of the directed plan: a word repeated count times
   typedef struct {
      kind_type     act;
      logic [7:0]   data;
      logic         lvl;
      int           count;
      logic         typed;
      rsp_word_type want;
   } plan_row_type;

   localparam rsp_word_type IDLE_WORD    = '0;
   localparam rsp_word_type STARTED_WORD = {1'b1, 1'b1, ST_NONE, 8'h00};
   localparam rsp_word_type REFUSED_LOW  = {1'b1, 1'b1, ST_REFUSED, 8'h00};
   localparam rsp_word_type READ_DONE_B4 = {1'b0, 1'b0, ST_READ_DONE, 8'hB4};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_action;
   logic [7:0] req_data_byte;
   logic       req_line_level;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_line_drive_low;
   logic       rsp_busy_res;
   logic [2:0] rsp_status;
   logic [7:0] rsp_read_value;
   logic       csr_we;
   logic [9:0] csr_wdata;

   // Bus engine copy kept by the testbench
   mode_type   eng_mode;
   logic [9:0] eng_us;
   logic [9:0] eng_prescale;
   logic [2:0] eng_bit;
   logic [7:0] eng_shift;
   logic       eng_presence;
   logic [9:0] eng_tpu;

   rsp_word_type pending_rsp[$];
   plan_row_type plan[$];
   int           mismatches;
   int           burst_left;
   int           cycles;
   logic         hold_request;

   one_wire_bus_master_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .req_line_level     (req_line_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_line_drive_low (rsp_line_drive_low),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Line pull of the running sequence at the current microsecond
   function automatic logic line_pulled();
      case (eng_mode)
         MODE_RESET: return eng_us < RST_LOW_US;
         MODE_WRITE: return eng_us < (eng_shift[0] ? W1_LOW_US : W0_LOW_US);
         MODE_READ:  return eng_us < RD_LOW_US;
         default:    return 1'b0;
      endcase
   endfunction

   // Advance the bus engine by one request word and return its response
   function automatic rsp_word_type step_bus_engine(input kind_type act, input logic [7:0] data,
                                                    input logic lvl);
      rsp_word_type r;
      logic [9:0]   t;
      r = '0;
      if (act != KIND_TICK) begin
         if (eng_mode != MODE_IDLE) begin
            // busy: refuse, engine stays put
            r.drive  = line_pulled();
            r.status = ST_REFUSED;
         end else begin
            eng_mode     = mode_type'(act);
            eng_us       = '0;
            eng_prescale = '0;
            eng_bit      = '0;
            eng_presence = 1'b0;
            eng_shift    = (act == KIND_WRITE) ? data : 8'h00;
            r.drive      = 1'b1;
         end
      end else if (eng_mode != MODE_IDLE) begin
         t       = eng_us;
         r.drive = line_pulled();
         // samples only on the first tick of the sample microsecond
         if (eng_prescale == 10'd0) begin
            if (eng_mode == MODE_RESET && t == RST_SAMPLE_US) eng_presence = ~lvl;
            if (eng_mode == MODE_READ && t == RD_SAMPLE_US) eng_shift = {lvl, eng_shift[7:1]};
         end
         eng_prescale = eng_prescale + 10'd1;
         if (eng_prescale >= eng_tpu) begin
            eng_prescale = '0;
            t = t + 10'd1;
         end
         eng_us = t;
         if (eng_mode == MODE_RESET) begin
            if (t == RST_END_US) begin
               r.status = eng_presence ? ST_PRESENCE : ST_NO_DEVICE;
               eng_mode = MODE_IDLE;
               eng_us   = '0;
            end
         end else if (t == SLOT_US) begin
            // end of a bit slot
            eng_us = '0;
            if (eng_mode == MODE_WRITE) eng_shift = eng_shift >> 1;
            if (eng_bit == LAST_BIT) begin
               if (eng_mode == MODE_WRITE) begin
                  r.status = ST_WRITE_DONE;
               end else begin
                  r.status = ST_READ_DONE;
                  r.value  = eng_shift;
               end
               eng_mode = MODE_IDLE;
               eng_bit  = '0;
            end else begin
               eng_bit = eng_bit + 3'd1;
            end
         end
      end
      r.busy = (eng_mode != MODE_IDLE);
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (mismatches < 100)
         $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
      mismatches++;
   endtask

   // Offer one request word in bursts with random gaps, then log its response
   task automatic send_word(input kind_type act, input logic [7:0] data, input logic lvl,
                            input logic typed, input rsp_word_type want);
      rsp_word_type due;
      int           gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_data_byte  <= data;
      req_line_level <= lvl;
      do @(posedge clock); while (!req_ready);
      due = step_bus_engine(act, data, lvl);
      pending_rsp.push_back(typed ? want : due);
   endtask

   // Drain all responses, then set ticks_per_us
   task automatic write_tpu(input logic [9:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we     <= 1'b0;
      eng_tpu    = v;
      burst_left = 0;
   endtask

   task automatic add_row(input kind_type act, input logic [7:0] data, input logic lvl,
                          input int count, input logic typed, input rsp_word_type want);
      plan_row_type row;
      row.act   = act;
      row.data  = data;
      row.lvl   = lvl;
      row.count = count;
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endtask

   // Response side: own stall pattern plus one long hold-off on request
   initial begin : rsp_side
      logic [15:0] pattern;
      logic        hold_done;
      int          hold_left;
      int          period;
      rsp_ready = 1'b0;
      pattern   = 16'hFFFF;
      hold_done = 1'b0;
      hold_left = 0;
      period    = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done  = 1'b1;
            hold_left  = 120;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
         end else begin
            if (period == 0) begin
               period  = $urandom_range(50, 300);
               pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                         : (16'($urandom) | 16'($urandom) | 16'h0101);
            end
            period--;
            rsp_ready <= pattern[0];
            pattern   = {pattern[0], pattern[15:1]};
         end
      end
   end

   // Compare each accepted response word with the oldest one due
   initial begin : rsp_check
      rsp_word_type w;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               flag_mismatch("response word with none due, status", int'(rsp_status), -1);
            end else begin
               w = pending_rsp.pop_front();
               if (rsp_line_drive_low !== w.drive)
                  flag_mismatch("line_drive_low", int'(rsp_line_drive_low), int'(w.drive));
               if (rsp_busy_res !== w.busy)
                  flag_mismatch("busy_res", int'(rsp_busy_res), int'(w.busy));
               if (rsp_status !== w.status)
                  flag_mismatch("status", int'(rsp_status), int'(w.status));
               if (rsp_read_value !== w.value)
                  flag_mismatch("read_value", int'(rsp_read_value), int'(w.value));
            end
         end
      end
   end

   // Run limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : main_flow
      logic [9:0] tpu_plan[NUM_PHASES];
      int         p;
      int         s;
      req_valid      = 1'b0;
      req_action     = KIND_TICK;
      req_data_byte  = 8'h00;
      req_line_level = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = 10'd0;
      hold_request   = 1'b0;
      mismatches     = 0;
      burst_left     = 0;
      eng_mode       = MODE_IDLE;
      eng_us         = '0;
      eng_prescale   = '0;
      eng_bit        = '0;
      eng_shift      = '0;
      eng_presence   = 1'b0;
      eng_tpu        = 10'd1;
      tpu_plan       = '{10'd0, 10'd3, 10'd1023, 10'd1};

      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed plan at the reset prescale: a full byte read of 0xB4; bits 3 and 7 span several rows
      add_row(KIND_TICK,  8'hFF, 1'b1, 3,  1'b1, IDLE_WORD);     // idle tick, ignored fields
      add_row(KIND_READ,  8'h81, 1'b0, 1,  1'b1, STARTED_WORD);
      add_row(KIND_WRITE, 8'h3C, 1'b0, 1,  1'b1, REFUSED_LOW);   // refused while busy
      add_row(KIND_RESET, 8'h00, 1'b1, 1,  1'b1, REFUSED_LOW);
      add_row(KIND_TICK,  8'h00, 1'b0, 70, 1'b0, IDLE_WORD);     // bit 0
      add_row(KIND_TICK,  8'hFF, 1'b0, 70, 1'b0, IDLE_WORD);     // bit 1
      add_row(KIND_TICK,  8'h00, 1'b1, 70, 1'b0, IDLE_WORD);     // bit 2
      add_row(KIND_TICK,  8'h00, 1'b0, 30, 1'b0, IDLE_WORD);
      add_row(KIND_WRITE, 8'h5A, 1'b1, 1,  1'b0, IDLE_WORD);     // refused with line released
      add_row(KIND_TICK,  8'h00, 1'b0, 40, 1'b0, IDLE_WORD);     // bit 3
      add_row(KIND_TICK,  8'h00, 1'b1, 70, 1'b0, IDLE_WORD);     // bit 4
      add_row(KIND_TICK,  8'h00, 1'b1, 70, 1'b0, IDLE_WORD);     // bit 5
      add_row(KIND_TICK,  8'h00, 1'b0, 70, 1'b0, IDLE_WORD);     // bit 6
      add_row(KIND_TICK,  8'h00, 1'b1, 69, 1'b0, IDLE_WORD);     // bit 7
      add_row(KIND_TICK,  8'h00, 1'b1, 1,  1'b1, READ_DONE_B4);
      add_row(KIND_TICK,  8'hC3, 1'b1, 2,  1'b1, IDLE_WORD);
      foreach (plan[i])
         repeat (plan[i].count)
            send_word(plan[i].act, plan[i].data, plan[i].lvl, plan[i].typed, plan[i].want);

      // Random words, one prescale setting per phase
      for (p = 0; p < NUM_PHASES; p++) begin
         write_tpu(tpu_plan[p]);
         if (p == 1) hold_request = 1'b1;
         for (s = 0; s < PHASE_WORDS; s++) begin
            if ($urandom_range(0, 5) == 0)
               send_word(kind_type'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
                         1'b0, '0);
            else
               send_word(KIND_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
         end
      end

      // Drain and settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/owbm_pkg.sv
sv/owbm_front.sv
sv/owbm_queue.sv
sv/owbm_back.sv
sv/one_wire_bus_master_top.sv
dv/tb.sv
